>>> rtl/tar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_pkg
// Shared types, register indexes, operation codes and float helpers for the
// axis reduction block.
// ----------------------------------------------------------------------------
package tar_pkg;

    typedef logic [31:0] word_t;
    typedef logic [10:0] dim_t;
    typedef logic [2:0]  cfg_idx_t;

    localparam cfg_idx_t REG_OP_MODE     = 3'd0;
    localparam cfg_idx_t REG_REDUCE_AXIS = 3'd1;
    localparam cfg_idx_t REG_DIM0        = 3'd2;
    localparam cfg_idx_t REG_DIM1        = 3'd3;
    localparam cfg_idx_t REG_DIM2        = 3'd4;
    localparam cfg_idx_t REG_DIM3        = 3'd5;

    localparam logic [1:0] OP_MAX = 2'd0;
    localparam logic [1:0] OP_MIN = 2'd1;

    localparam logic [1:0] AXIS0 = 2'd0;
    localparam logic [1:0] AXIS1 = 2'd1;
    localparam logic [1:0] AXIS2 = 2'd2;
    localparam logic [1:0] AXIS3 = 2'd3;

    localparam word_t FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam word_t FP_QUIET_BIT   = 32'h0040_0000;
    localparam word_t FP_POS_ZERO    = 32'h0000_0000;

    function automatic logic fp_is_nan(input word_t v);
        fp_is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // ordered p < q; false on any NaN and on equal zeros
    function automatic logic fp_less(input word_t p, input word_t q);
        logic res;
        res = 1'b0;
        if (!fp_is_nan(p) && !fp_is_nan(q) && ((p[30:0] | q[30:0]) != 31'd0))
        begin
            if (p[31] != q[31])
            begin
                res = p[31];
            end
            else if (!p[31])
            begin
                res = p[30:0] < q[30:0];
            end
            else
            begin
                res = p[30:0] > q[30:0];
            end
        end
        fp_less = res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tar_fp_add.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_fp_add
// Single precision adder, round to nearest even, one combinational pass.
// ----------------------------------------------------------------------------
module tar_fp_add
(
    input  wire tar_pkg::word_t a,
    input  wire tar_pkg::word_t b,
    output tar_pkg::word_t      sum
);
    import tar_pkg::*;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd27;
        hit = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                n   = 5'(26 - i);
                hit = 1'b1;
            end
        end
        lzc27 = n;
    endfunction

    word_t        big, sml;
    logic [7:0]   big_e, sml_e, diff;
    logic [23:0]  big_m, sml_m;
    logic [4:0]   dcap;
    logic [53:0]  wide;
    logic [26:0]  ax, bx;
    logic [27:0]  s28;
    logic [26:0]  m1, m2;
    logic [9:0]   e1, emax, sh, e2, ef;
    logic [4:0]   lz;
    logic         inc;
    logic [24:0]  r;
    logic [22:0]  mf;
    word_t        norm;

    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        big_m = {big[30:23] != 8'd0, big[22:0]};
        sml_m = {sml[30:23] != 8'd0, sml[22:0]};
        diff  = big_e - sml_e;
        dcap  = (diff > 8'd27) ? 5'd27 : diff[4:0];
        wide  = {sml_m, 30'd0} >> dcap;
        bx    = {wide[53:28], wide[27] | (|wide[26:0])};
        ax    = {big_m, 3'd0};
        if (big[31] ^ sml[31])
        begin
            s28 = {1'b0, ax} - {1'b0, bx};
        end
        else
        begin
            s28 = {1'b0, ax} + {1'b0, bx};
        end
        if (s28[27])
        begin
            m1 = {s28[27:2], s28[1] | s28[0]};
            e1 = {2'd0, big_e} + 10'd1;
        end
        else
        begin
            m1 = s28[26:0];
            e1 = {2'd0, big_e};
        end
        lz   = lzc27(m1);
        emax = e1 - 10'd1;
        sh   = ({5'd0, lz} > emax) ? emax : {5'd0, lz};
        m2   = m1 << sh[4:0];
        e2   = e1 - sh;
        inc  = m2[2] & ((|m2[1:0]) | m2[3]);
        r    = {1'b0, m2[26:3]} + {24'd0, inc};
        if (r[24])
        begin
            ef = e2 + 10'd1;
            mf = r[23:1];
        end
        else
        begin
            ef = r[23] ? e2 : 10'd0;
            mf = r[22:0];
        end
        if (m1 == 27'd0)
        begin
            norm = FP_POS_ZERO;
        end
        else if (ef >= 10'd255)
        begin
            norm = {big[31], 8'hFF, 23'd0};
        end
        else
        begin
            norm = {big[31], ef[7:0], mf};
        end

        if (fp_is_nan(a))
        begin
            sum = a | FP_QUIET_BIT;
        end
        else if (fp_is_nan(b))
        begin
            sum = b | FP_QUIET_BIT;
        end
        else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
        begin
            sum = (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
        end
        else if (a[30:23] == 8'hFF)
        begin
            sum = a;
        end
        else if (b[30:23] == 8'hFF)
        begin
            sum = b;
        end
        else if ((a[30:0] | b[30:0]) == 31'd0)
        begin
            sum = {a[31] & b[31], 31'd0};
        end
        else
        begin
            sum = norm;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tensor_axis_reduce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_axis_reduce
// Max, min or sum reduction of a float32 tensor of up to four dimensions
// along one configured axis, with a partial-result store per output position.
// Each accepted element is registered into stage s1, each finished result
// into the output register. Throughput: one element per cycle unless the
// output stalls; the store read and the adder or compare on one accumulator
// fit in one stage, with a bypass for back-to-back hits. After reset or a
// register write the input stalls while the store capacity check settles.
// Reset sets registers to defaults, indexes to zero; the store is not cleared.
// ----------------------------------------------------------------------------
module tensor_axis_reduce
#(
    parameter int MAX_INNER = 1024,
    parameter int MAX_DIM   = 1024
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire tar_pkg::cfg_idx_t cfg_index,
    input  wire tar_pkg::dim_t     cfg_data,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire tar_pkg::word_t    element_bits,
    output logic                   out_valid,
    input  wire                    out_ready,
    output tar_pkg::word_t         reduced_bits,
    output logic                   final_result,
    output logic                   size_error
);
    import tar_pkg::*;

    localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    function automatic dim_t eff_dim(input dim_t v);
        dim_t res;
        res = v;
        if (v == 11'd0)
        begin
            res = 11'd1;
        end
        else if ({21'd0, v} > MAX_DIM)
        begin
            res = 11'(MAX_DIM);
        end
        eff_dim = res;
    endfunction

    logic [1:0]    op_reg, axis_reg;
    dim_t          dim_reg [4];
    dim_t          idx_reg [4];
    dim_t          idx_next [4];
    logic [AW-1:0] addr_reg;
    logic [1:0]    settle_reg;
    logic [21:0]   p23_reg;
    logic          err_reg;
    logic          err_next;
    logic [32:0]   p123;

    logic [3:0]    at_last;
    logic          carry;
    logic          wrap, first_c, last_c, final_c;
    logic          cfg_hit;

    logic          s1_valid_reg, s1_first_reg, s1_last_reg, s1_final_reg;
    logic [AW-1:0] s1_addr_reg;
    word_t         s1_x_reg;
    word_t         mem_q_reg;
    logic          fwd_reg;
    word_t         fwd_data_reg;
    word_t         mem [MAX_INNER];

    word_t         acc_old, add_a, add_sum, s1_result;
    logic          s1_go, out_free, accept;

    logic          out_valid_reg, out_final_reg, out_err_reg;
    word_t         out_data_reg;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index <= REG_DIM3);
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_go     = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready  = (!s1_valid_reg || s1_go) && (settle_reg == 2'd0);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        carry   = 1'b1;
        wrap    = 1'b1;
        final_c = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            at_last[i] = (idx_reg[i] == dim_reg[i] - 11'd1);
        end
        for (int i = 3; i >= 0; i--)
        begin
            idx_next[i] = idx_reg[i];
            if (carry)
            begin
                idx_next[i] = at_last[i] ? 11'd0 : idx_reg[i] + 11'd1;
            end
            carry   = carry & at_last[i];
            final_c = final_c & at_last[i];
            if (i > int'(axis_reg))
            begin
                wrap = wrap & at_last[i];
            end
        end
        first_c = (idx_reg[axis_reg] == 11'd0);
        last_c  = at_last[axis_reg];
    end

    assign p123 = p23_reg * dim_reg[1];

    always_comb
    begin
        case (axis_reg)
            AXIS3:   err_next = 1'b0;
            AXIS2:   err_next = {23'd0, dim_reg[3]} > 34'(MAX_INNER);
            AXIS1:   err_next = {12'd0, p23_reg} > 34'(MAX_INNER);
            default: err_next = ({12'd0, p23_reg} > 34'(MAX_INNER))
                                || ({1'b0, p123} > 34'(MAX_INNER));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_MAX;
            axis_reg   <= AXIS0;
            settle_reg <= 2'd2;
            p23_reg    <= 22'd1;
            err_reg    <= 1'b0;
            addr_reg   <= '0;
            for (int i = 0; i < 4; i++)
            begin
                dim_reg[i] <= 11'd1;
                idx_reg[i] <= 11'd0;
            end
        end
        else
        begin
            p23_reg <= dim_reg[2] * dim_reg[3];
            err_reg <= err_next;
            if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (cfg_hit)
            begin
                case (cfg_index)
                    REG_OP_MODE:     op_reg     <= cfg_data[1:0];
                    REG_REDUCE_AXIS: axis_reg   <= cfg_data[1:0];
                    REG_DIM0:        dim_reg[0] <= eff_dim(cfg_data);
                    REG_DIM1:        dim_reg[1] <= eff_dim(cfg_data);
                    REG_DIM2:        dim_reg[2] <= eff_dim(cfg_data);
                    default:         dim_reg[3] <= eff_dim(cfg_data);
                endcase
                settle_reg <= 2'd2;
                addr_reg   <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    idx_reg[i] <= 11'd0;
                end
            end
            else if (accept)
            begin
                addr_reg <= wrap ? '0 : addr_reg + 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    idx_reg[i] <= idx_next[i];
                end
            end
        end
    end

    always_comb
    begin
        acc_old = fwd_reg ? fwd_data_reg : mem_q_reg;
        add_a   = s1_first_reg ? FP_POS_ZERO : acc_old;
        if (op_reg[1])
        begin
            s1_result = add_sum;
        end
        else if (s1_first_reg)
        begin
            s1_result = s1_x_reg;
        end
        else if (op_reg == OP_MAX)
        begin
            s1_result = fp_less(acc_old, s1_x_reg) ? s1_x_reg : acc_old;
        end
        else
        begin
            s1_result = fp_less(s1_x_reg, acc_old) ? s1_x_reg : acc_old;
        end
    end

    tar_fp_add u_add
    (
        .a   (add_a),
        .b   (s1_x_reg),
        .sum (add_sum)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_q_reg    <= mem[addr_reg];
            fwd_reg      <= s1_go && !err_reg && (s1_addr_reg == addr_reg);
            fwd_data_reg <= s1_result;
            s1_x_reg     <= element_bits;
            s1_addr_reg  <= addr_reg;
            s1_first_reg <= first_c;
            s1_last_reg  <= last_c;
            s1_final_reg <= final_c;
        end
        if (s1_go && !err_reg)
        begin
            mem[s1_addr_reg] <= s1_result;
        end
        if (s1_go && s1_last_reg)
        begin
            out_data_reg  <= err_reg ? FP_POS_ZERO : s1_result;
            out_final_reg <= s1_final_reg;
            out_err_reg   <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign reduced_bits = out_data_reg;
    assign final_result = out_final_reg;
    assign size_error   = out_err_reg;

endmodule
`default_nettype wire

>>> verif/tensor_axis_reduce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_axis_reduce_tb
// Self-checking bench for the axis reduction block. A queue-fed driver streams
// float32 elements, a clocked monitor compares every result against a
// bit-exact behavioural predictor (IEEE compares and a round-to-nearest-even
// adder), across directed corner cases and randomised tensor shapes,
// operations and handshake pressure.
// ----------------------------------------------------------------------------
module tensor_axis_reduce_tb;
    import tar_pkg::*;

    localparam logic [1:0] OP_SUM   = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam cfg_idx_t   REG_UNUSED = 3'd6;
    localparam int STORE_DEPTH = 1024;
    localparam int DIM_LIMIT   = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 450;
    localparam int MIN_PHASES   = 6;

    typedef struct packed {
        word_t bits;
        logic  last_of_tensor;
        logic  overflow;
    } reduced_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_valid = 1'b0;
    cfg_idx_t cfg_index = '0;
    dim_t     cfg_data = '0;
    logic     in_valid = 1'b0;
    word_t    element_bits = '0;
    logic     out_ready = 1'b0;
    wire      cfg_ready;
    wire      in_ready;
    wire      out_valid;
    word_t    reduced_bits;
    wire      final_result;
    wire      size_error;

    word_t    element_q[$];
    reduced_t reduced_q[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     hold_kick = 1'b0;
    int       hold_left = 0;

    logic [1:0]  op_sh;
    logic [1:0]  axis_sh;
    logic [10:0] dim_sh[4];
    word_t       partial_sh[STORE_DEPTH];
    int          pos_sh[4];

    tensor_axis_reduce uut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .element_bits(element_bits),
        .out_valid(out_valid), .out_ready(out_ready),
        .reduced_bits(reduced_bits), .final_result(final_result),
        .size_error(size_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_nan(word_t v);
        return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    function automatic logic ordered_below(word_t p, word_t q);
        if (is_nan(p) || is_nan(q) || (p[30:0] | q[30:0]) == 31'd0)
        begin
            return 1'b0;
        end
        if (p[31] != q[31])
        begin
            return p[31];
        end
        return p[31] ? (p[30:0] > q[30:0]) : (p[30:0] < q[30:0]);
    endfunction

    function automatic word_t float_add(word_t a, word_t b);
        word_t       t;
        logic [63:0] xa;
        logic [63:0] xb;
        logic [63:0] s;
        logic [29:0] rem;
        logic [24:0] mant;
        logic        sticky;
        logic        up;
        int          ea;
        int          eb;
        int          d;
        int          p;
        int          sh;
        int          e;
        if (is_nan(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (is_nan(b))
        begin
            return b | FP_QUIET_BIT;
        end
        if (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000 && a[31] != b[31])
        begin
            return FP_DEFAULT_NAN;
        end
        if (a[30:23] == 8'hFF)
        begin
            return a;
        end
        if (b[30:23] == 8'hFF)
        begin
            return b;
        end
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (a[30:0] == 31'd0)
        begin
            return b;
        end
        if (b[30:0] == 31'd0)
        begin
            return a;
        end
        if (a[30:0] < b[30:0])
        begin
            t = a;
            a = b;
            b = t;
        end
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        xa = {40'd0, a[30:23] != 8'd0, a[22:0]} << 30;
        xb = {40'd0, b[30:23] != 8'd0, b[22:0]} << 30;
        d = ea - eb;
        if (d >= 60)
        begin
            xb = 64'd1;
        end
        else
        begin
            sticky = |(xb & ((64'd1 << d) - 64'd1));
            xb = (xb >> d) | {63'd0, sticky};
        end
        s = (a[31] == b[31]) ? xa + xb : xa - xb;
        if (s == 64'd0)
        begin
            return FP_POS_ZERO;
        end
        p = 63;
        while (!s[p])
        begin
            p--;
        end
        e = ea;
        if (p > 53)
        begin
            s = (s >> 1) | {63'd0, s[0]};
            e++;
        end
        else if (p < 53)
        begin
            sh = 53 - p;
            if (sh > e - 1)
            begin
                sh = e - 1;
            end
            s = s << sh;
            e -= sh;
        end
        rem = s[29:0];
        up = rem > 30'h2000_0000 || (rem == 30'h2000_0000 && s[30]);
        mant = {1'b0, s[53:30]} + {24'd0, up};
        if (mant[24])
        begin
            mant = mant >> 1;
            e++;
        end
        if (e >= 255)
        begin
            return {a[31], 8'hFF, 23'd0};
        end
        return {a[31], mant[23] ? 8'(e) : 8'd0, mant[22:0]};
    endfunction

    function automatic int extent(logic [10:0] v);
        if (v == 11'd0)
        begin
            return 1;
        end
        return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
    endfunction

    task automatic reduce_element(word_t x);
        int       d[4];
        longint   inner;
        int       addr;
        int       ax;
        logic     overflow;
        logic     axis_end;
        logic     tensor_end;
        word_t    acc;
        reduced_t r;
        ax = axis_sh;
        inner = 1;
        addr = 0;
        acc = '0;
        tensor_end = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            d[i] = extent(dim_sh[i]);
            if (pos_sh[i] >= d[i])
            begin
                pos_sh[i] = d[i] - 1;
            end
        end
        for (int i = ax + 1; i < 4; i++)
        begin
            inner *= d[i];
            addr = addr * d[i] + pos_sh[i];
        end
        overflow = inner > STORE_DEPTH;
        axis_end = pos_sh[ax] + 1 >= d[ax];
        if (!overflow)
        begin
            acc = partial_sh[addr];
            if (op_sh[1])
            begin
                acc = float_add(pos_sh[ax] == 0 ? FP_POS_ZERO : acc, x);
            end
            else if (pos_sh[ax] == 0)
            begin
                acc = x;
            end
            else if (op_sh == OP_MAX)
            begin
                if (ordered_below(acc, x))
                begin
                    acc = x;
                end
            end
            else if (ordered_below(x, acc))
            begin
                acc = x;
            end
            partial_sh[addr] = acc;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (pos_sh[i] + 1 < d[i])
            begin
                tensor_end = 1'b0;
            end
        end
        for (int i = 3; i >= 0; i--)
        begin
            pos_sh[i]++;
            if (pos_sh[i] < d[i])
            begin
                break;
            end
            pos_sh[i] = 0;
        end
        if (axis_end)
        begin
            r.bits = overflow ? '0 : acc;
            r.last_of_tensor = tensor_end;
            r.overflow = overflow;
            reduced_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                reduce_element(element_bits);
            end
            if (!in_valid || in_ready)
            begin
                if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    element_bits <= element_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_kick)
        begin
            hold_left <= 300;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        reduced_t w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reduced_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer bits=%h final=%b err=%b", $time,
                             reduced_bits, final_result, size_error);
                    errors++;
                end
                else
                begin
                    w = reduced_q.pop_front();
                    if (reduced_bits !== w.bits)
                    begin
                        $display("%0t: reduced_bits expected %h actual %h", $time,
                                 w.bits, reduced_bits);
                        errors++;
                    end
                    if (final_result !== w.last_of_tensor)
                    begin
                        $display("%0t: final_result expected %b actual %b", $time,
                                 w.last_of_tensor, final_result);
                        errors++;
                    end
                    if (size_error !== w.overflow)
                    begin
                        $display("%0t: size_error expected %b actual %b", $time,
                                 w.overflow, size_error);
                        errors++;
                    end
                end
            end
            out_ready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, dim_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OP_MODE:     op_sh = val[1:0];
            REG_REDUCE_AXIS: axis_sh = val[1:0];
            REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: dim_sh[idx - REG_DIM0] = val;
            default: return;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            pos_sh[i] = 0;
        end
    endtask

    task automatic set_tensor(logic [1:0] op, logic [1:0] ax, dim_t d0, dim_t d1,
                              dim_t d2, dim_t d3);
        write_reg(REG_OP_MODE, dim_t'(op));
        write_reg(REG_REDUCE_AXIS, dim_t'(ax));
        write_reg(REG_DIM0, d0);
        write_reg(REG_DIM1, d1);
        write_reg(REG_DIM2, d2);
        write_reg(REG_DIM3, d3);
    endtask

    task automatic drain();
        while (element_q.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (reduced_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_idling(int k);
        send_idle_pct = (k % 4 == 1) ? 56 : (k % 4 == 3) ? 28 : 0;
        recv_stall_pct = (k % 4 == 2) ? 56 : (k % 4 == 3) ? 28 : 0;
    endtask

    function automatic word_t random_element(word_t prev);
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return {1'($urandom_range(1)), 8'($urandom_range(120, 134)),
                                23'($urandom)};
            7: return prev ^ 32'h8000_0000;
            8: return {1'($urandom_range(1)), 8'($urandom_range(1)), 23'($urandom)};
            default:
                case ($urandom_range(5))
                    0: return 32'h7F80_0000;
                    1: return 32'hFF80_0000;
                    2: return 32'h7FC0_0000;
                    3: return 32'h8000_0000;
                    4: return 32'h7F7F_FFFF;
                    default: return 32'h0000_0000;
                endcase
        endcase
    endfunction

    initial
    begin
        word_t    prev;
        int       sent;
        int       total;
        int       n;
        int       ph;
        dim_t     dd[4];
        logic [1:0] op;
        logic [1:0] ax;

        op_sh = OP_MAX;
        axis_sh = AXIS0;
        for (int i = 0; i < 4; i++)
        begin
            dim_sh[i] = 11'd1;
            pos_sh[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_tensor(OP_MAX, AXIS3, 11'd1, 11'd1, 11'd2, 11'd4);
        element_q = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h3F80_0000,
                      32'hFF80_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h0000_0001};
        drain();
        write_reg(REG_OP_MODE, dim_t'(OP_MIN));
        element_q = '{32'h8000_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'h7FFF_FFFF,
                      32'h7FC0_0000, 32'hFF80_0000, 32'h0000_0001, 32'h8000_0001};
        drain();
        write_reg(REG_OP_MODE, dim_t'(OP_SUM));
        element_q = '{32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001};
        drain();
        write_reg(REG_UNUSED, 11'h7FF);
        set_tensor(OP_UNDEF, AXIS1, 11'd0, 11'd3, 11'd0, 11'd2);
        element_q = '{32'h3F80_0000, 32'h4000_0000, 32'hBF80_0000, 32'h3400_0000,
                      32'h4B80_0000, 32'h3F80_0001};
        drain();
        set_tensor(OP_SUM, AXIS1, 11'd2, 11'd1, 11'd2, 11'd1024);
        repeat (12) element_q.push_back($urandom);
        drain();

        set_tensor(OP_MAX, AXIS3, 11'd1, 11'd1, 11'd1, 11'h7FF);
        prev = '0;
        for (int i = 0; i < 1024; i++)
        begin
            prev = random_element(prev);
            element_q.push_back(prev);
        end
        drain();
        set_tensor(OP_MIN, AXIS0, 11'd1, 11'd33, 11'd32, 11'd1);
        for (int i = 0; i < 40; i++)
        begin
            element_q.push_back($urandom);
        end
        drain();

        sent = 0;
        ph = 0;
        while (sent < RANDOM_ITEMS || ph < MIN_PHASES)
        begin
            set_idling(ph);
            op = 2'($urandom_range(3));
            ax = 2'($urandom_range(3));
            total = 1;
            for (int i = 0; i < 4; i++)
            begin
                dd[i] = ($urandom_range(15) == 0) ? dim_t'($urandom_range(6, 9))
                                                  : dim_t'($urandom_range(0, 4));
                total *= extent(dd[i]);
            end
            set_tensor(op, ax, dd[0], dd[1], dd[2], dd[3]);
            n = total * $urandom_range(1, 2);
            if ($urandom_range(3) == 0)
            begin
                n += $urandom_range(total);
            end
            if (ph == 3)
            begin
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
                n += 200;
            end
            for (int i = 0; i < n; i++)
            begin
                prev = random_element(prev);
                element_q.push_back(prev);
                if (ph == 5 && i == n / 2)
                begin
                    drain();
                end
            end
            sent += n;
            drain();
            ph++;
        end

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/tar_pkg.sv
rtl/tar_fp_add.sv
rtl/tensor_axis_reduce.sv
verif/tensor_axis_reduce_tb.sv
